/* src/huffman_code_bit_packer_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hcbp_pkg.sv */
`timescale 1ns / 1ps
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int RESULT_LIMIT_LEN = 40;
  localparam int BITS_PER_BYTE = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int SYM_W = 8;
  localparam int TOTAL_W = 32;
  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_CAP =
    (MAX_CODE_LEN > RESULT_LIMIT_LEN) ? RESULT_LIMIT_LEN : MAX_CODE_LEN;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_TOTAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  // One pass of the shift unit.
  typedef struct packed {
    logic              byte_done;
    logic [7:0]        byte_val;
    logic [6:0]        acc;
    logic [2:0]        cnt;
    logic [LEN_W-1:0]  rem;
  } step_t;

endpackage

/* src/hcbp_in_if.sv */
`timescale 1ns / 1ps
interface hcbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [hcbp_pkg::SYM_W-1:0]    symbol;
  logic [hcbp_pkg::LEN_W-1:0]    code_length;
  logic [hcbp_pkg::CODE_W-1:0]   code_bits;

  modport source (output valid, action, symbol, code_length, code_bits, input ready);
  modport sink (input valid, action, symbol, code_length, code_bits, output ready);
endinterface

/* src/hcbp_out_if.sv */
`timescale 1ns / 1ps
interface hcbp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [7:0]                    out_byte;
  logic [hcbp_pkg::TOTAL_W-1:0]  byte_total;
  logic                          last;

  modport source (output valid, kind, out_byte, byte_total, last, input ready);
  modport sink (input valid, kind, out_byte, byte_total, last, output ready);
endinterface

/* src/hcbp_code_mem.sv */
`timescale 1ns / 1ps
module hcbp_code_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [hcbp_pkg::ADDR_W-1:0]   wr_addr,
  input  hcbp_pkg::entry_t              wr_entry,
  input  logic                          re,
  input  logic [hcbp_pkg::ADDR_W-1:0]   rd_addr,
  output hcbp_pkg::entry_t              rd_entry
);

  hcbp_pkg::entry_t mem [hcbp_pkg::SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

/* src/hcbp_shift_unit.sv */
`timescale 1ns / 1ps
module hcbp_shift_unit (
  input  logic [6:0]                    acc,
  input  logic [2:0]                    cnt,
  input  logic [hcbp_pkg::CODE_W-1:0]   code,
  input  logic [hcbp_pkg::LEN_W-1:0]    rem,
  output hcbp_pkg::step_t               step
);

  localparam int WIDE_W = hcbp_pkg::RESULT_LIMIT_LEN;

  logic [3:0]                  space;
  logic [3:0]                  take;
  logic [3:0]                  total;
  logic [hcbp_pkg::LEN_W-1:0]  shamt;
  logic [WIDE_W-1:0]           wide;
  logic [7:0]                  mask;
  logic [7:0]                  chunk;
  logic [15:0]                 shifted;
  logic [7:0]                  merged;
  logic                        done;

  always_comb begin
    // Take as many bits as fit in the open byte, earliest first.
    space   = 4'(hcbp_pkg::BITS_PER_BYTE) - {1'b0, cnt};
    take    = (rem < {2'b00, space}) ? rem[3:0] : space;
    shamt   = rem - {2'b00, take};
    wide    = {{(WIDE_W - hcbp_pkg::CODE_W){1'b0}}, code} >> shamt;
    mask    = 8'((9'h001 << take) - 9'h001);
    chunk   = wide[7:0] & mask;
    shifted = {9'h000, acc} << take;
    merged  = shifted[7:0] | chunk;
    total   = {1'b0, cnt} + take;
    done    = (total == 4'(hcbp_pkg::BITS_PER_BYTE));

    step.byte_done = done;
    step.byte_val  = merged;
    step.acc       = done ? 7'd0 : merged[6:0];
    step.cnt       = done ? 3'd0 : total[2:0];
    step.rem       = shamt;
  end

endmodule

/* src/huffman_code_bit_packer_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Handshake
// in_ch     in   action, symbol, code_length, code_bits    valid/ready
// out_ch    out  kind, out_byte, byte_total, last          valid/ready
//
// Load: the table is written on acceptance and input stays ready. Encode:
// a table read in ST_FETCH, then one shift-unit pass per cycle in ST_ENC
// taking up to 8 bits, then a closing step; the input is held off throughout.
// Flush: one pass for the padded byte if bits are pending, a closing step,
// then the count. Every pass and the count wait while the output register
// holds an item not yet taken.
// Reset (rst, synchronous) clears the bit accumulator and the byte count;
// table entries hold nothing until loaded.
module huffman_code_bit_packer_core (
  input  logic         clk,
  input  logic         rst,
  hcbp_in_if.sink      in_ch,
  hcbp_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_ENC   = 4'b0100,
    ST_COUNT = 4'b1000
  } state_t;

  state_t                          state, state_next;
  logic [6:0]                      acc;
  logic [2:0]                      cnt;
  logic [hcbp_pkg::CODE_W-1:0]     code;
  logic [hcbp_pkg::LEN_W-1:0]      rem;
  logic                            flushing;
  logic [hcbp_pkg::TOTAL_W-1:0]    emitted;

  logic                            in_acc;
  logic                            sym_ok;
  logic                            slot_free;
  logic                            do_step;
  logic                            emit_data;
  logic                            emit_total;
  logic [hcbp_pkg::LEN_W-1:0]      len_capped;
  hcbp_pkg::entry_t                wr_entry;
  hcbp_pkg::entry_t                rd_entry;
  hcbp_pkg::step_t                 step;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign sym_ok      = ({1'b0, in_ch.symbol} < 9'(hcbp_pkg::SYMBOL_COUNT));
  assign slot_free   = !out_ch.valid || out_ch.ready;
  assign do_step     = (state == ST_ENC) && (rem != '0) && slot_free;
  assign emit_data   = do_step && step.byte_done;
  assign emit_total  = (state == ST_COUNT) && slot_free;

  assign len_capped = (in_ch.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP))
                      ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : in_ch.code_length;
  assign wr_entry.len  = len_capped;
  assign wr_entry.code = in_ch.code_bits;

  hcbp_code_mem u_mem (
    .clk      (clk),
    .we       (in_acc && (in_ch.action == hcbp_pkg::ACT_LOAD) && sym_ok),
    .wr_addr  (in_ch.symbol[hcbp_pkg::ADDR_W-1:0]),
    .wr_entry (wr_entry),
    .re       (in_acc && (in_ch.action == hcbp_pkg::ACT_ENCODE)),
    .rd_addr  (in_ch.symbol[hcbp_pkg::ADDR_W-1:0]),
    .rd_entry (rd_entry)
  );

  hcbp_shift_unit u_shift (
    .acc  (acc),
    .cnt  (cnt),
    .code (code),
    .rem  (rem),
    .step (step)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_ch.action == hcbp_pkg::ACT_ENCODE && sym_ok) begin
            state_next = ST_FETCH;
          end else if (in_ch.action == hcbp_pkg::ACT_FLUSH) begin
            state_next = ST_ENC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FETCH: state_next = ST_ENC;
      ST_ENC: begin
        if (rem == '0) begin
          state_next = flushing ? ST_COUNT : ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc      <= '0;
      cnt      <= '0;
      emitted  <= '0;
      flushing <= 1'b0;
      rem      <= '0;
    end else begin
      state <= state_next;
      if (in_acc && in_ch.action == hcbp_pkg::ACT_FLUSH) begin
        // Pad the open byte with zeros through the shift unit.
        flushing <= 1'b1;
        rem      <= (cnt == '0) ? '0
                    : hcbp_pkg::LEN_W'(4'(hcbp_pkg::BITS_PER_BYTE) - {1'b0, cnt});
      end else if (state == ST_FETCH) begin
        flushing <= 1'b0;
        rem      <= rd_entry.len;
      end else if (do_step) begin
        rem <= step.rem;
      end
      if (do_step) begin
        acc <= step.acc;
        cnt <= step.cnt;
      end
      if (emit_data && emitted != '1) begin
        emitted <= emitted + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == hcbp_pkg::ACT_FLUSH) begin
      code <= '0;
    end else if (state == ST_FETCH) begin
      code <= rd_entry.code;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit_data || emit_total) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_data) begin
      out_ch.kind       <= hcbp_pkg::KIND_DATA;
      out_ch.out_byte   <= step.byte_val;
      out_ch.byte_total <= '0;
      // No further byte of this code can follow once fewer than eight bits remain.
      out_ch.last       <= !flushing && (step.rem < hcbp_pkg::LEN_W'(hcbp_pkg::BITS_PER_BYTE));
    end else if (emit_total) begin
      out_ch.kind       <= hcbp_pkg::KIND_TOTAL;
      out_ch.out_byte   <= '0;
      out_ch.byte_total <= emitted;
      out_ch.last       <= 1'b1;
    end
  end

endmodule

/* src/hcbp_checker.sv */
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_core_defines.svh"
module hcbp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [7:0]                    out_byte,
  input logic                          out_last
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `HCBP_ASSERT_NEXT(a_load_one_cycle, in_acc && in_action == hcbp_pkg::ACT_LOAD, in_ready, "load item did not return to ready")
  `HCBP_ASSERT_NEXT(a_flush_busy, in_acc && in_action == hcbp_pkg::ACT_FLUSH, !in_ready, "flush item did not hold off input")
  `HCBP_ASSERT_NOW(a_total_is_last, out_valid && out_kind == hcbp_pkg::KIND_TOTAL, out_last && out_byte == 8'h00, "count item not marked last or byte not zero")
  `HCBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled output item changed")

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

/* bench/huffman_code_bit_packer_core_tb.sv */
`timescale 1ns / 1ps
module huffman_code_bit_packer_core_tb;
  import hcbp_pkg::*;

  localparam int RAND_ITEMS  = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_PRINTS  = 100;
  localparam int DIR_N       = 24;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   out_byte;
    logic [31:0]  byte_total;
    logic         last;
  } beat_t;

  typedef struct packed {
    action_t      act;
    logic [7:0]   sym;
    logic [5:0]   len;
    logic [31:0]  bits;
    logic         typed;
    logic [1:0]   n_typed;
    beat_t        b0;
    beat_t        b1;
  } row_t;

  localparam beat_t NO_BEAT = '0;

  // Typed rows carry their results; the rest take theirs from pack_item.
  localparam row_t DIR_ROWS [DIR_N] = '{
    '{ACT_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b1, 2'd1,
      '{KIND_TOTAL, 8'h00, 32'd0, 1'b1}, NO_BEAT},
    '{ACT_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h00, 6'd0,  32'h0000_0000, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_LOAD,   8'hFF, 6'd8,  32'h0000_00A5, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 2'd1,
      '{KIND_DATA, 8'hA5, 32'd0, 1'b1}, NO_BEAT},
    '{ACT_LOAD,   8'h80, 6'd32, 32'hFFFF_FFFF, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h80, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_LOAD,   8'h01, 6'd63, 32'h1234_5678, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h01, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_LOAD,   8'h7F, 6'd1,  32'h0000_0001, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h7F, 6'd0,  32'h0000_0000, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_NONE,   8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b1, 2'd2,
      '{KIND_DATA, 8'h80, 32'd0, 1'b0}, '{KIND_TOTAL, 8'h00, 32'd10, 1'b1}},
    '{ACT_LOAD,   8'h55, 6'd7,  32'h0000_0055, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h55, 6'd0,  32'h0000_0000, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h55, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_LOAD,   8'h02, 6'd32, 32'h0000_0000, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h02, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h80, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_FLUSH,  8'hFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_LOAD,   8'h03, 6'd32, 32'h8000_0001, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_ENCODE, 8'h03, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{ACT_FLUSH,  8'h00, 6'd0,  32'h0000_0000, 1'b0, 2'd0, NO_BEAT, NO_BEAT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Packer state as the block should hold it.
  logic [31:0] code_tab [SYMBOL_COUNT];
  logic [5:0]  len_tab [SYMBOL_COUNT];
  bit          loaded [SYMBOL_COUNT];
  logic [7:0]  loaded_syms [$];
  logic [6:0]  acc_bits;
  logic [2:0]  acc_count;
  logic [31:0] bytes_sent;

  beat_t step_beats [$];
  beat_t owed_beats [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet_tx = 1'b0;
  bit  quiet_rx = 1'b0;
  bit  hold_req = 1'b0;

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at %0t: %s want 0x%0h got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic void add_data(logic [7:0] b);
    step_beats.push_back('{KIND_DATA, b, 32'd0, 1'b0});
    if (bytes_sent != 32'hFFFF_FFFF)
      bytes_sent = bytes_sent + 1;
  endfunction

  // Work out the beats one accepted item causes and advance the packer state.
  function automatic void pack_item(action_t act, logic [7:0] sym, logic [5:0] len,
                                    logic [31:0] bits);
    logic [7:0] acc;
    int         cnt;
    int         pos;
    step_beats.delete();
    case (act)
      ACT_LOAD: begin
        code_tab[sym] = bits;
        len_tab[sym]  = (int'(len) > LEN_CAP) ? 6'(LEN_CAP) : len;
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      ACT_ENCODE: begin
        acc = {1'b0, acc_bits};
        cnt = int'(acc_count);
        for (int i = int'(len_tab[sym]); i > 0; i--) begin
          pos = i - 1;
          acc = {acc[6:0], (pos < 32) ? code_tab[sym][pos] : 1'b0};
          cnt++;
          if (cnt == BITS_PER_BYTE) begin
            add_data(acc);
            acc = '0;
            cnt = 0;
          end
        end
        acc_bits  = acc[6:0];
        acc_count = 3'(cnt);
        if (step_beats.size() > 0)
          step_beats[step_beats.size() - 1].last = 1'b1;
      end
      ACT_FLUSH: begin
        if (acc_count != 3'd0) begin
          acc = 8'({1'b0, acc_bits} << (BITS_PER_BYTE - int'(acc_count)));
          add_data(acc);
        end
        acc_bits  = '0;
        acc_count = '0;
        step_beats.push_back('{KIND_TOTAL, 8'h00, bytes_sent, 1'b1});
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(action_t act, logic [7:0] sym, logic [5:0] len,
                           logic [31:0] bits);
    int gap;
    if ($urandom_range(0, 31) == 0)
      quiet_tx = !quiet_tx;
    gap = quiet_tx ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.symbol      <= sym;
    in_ch.code_length <= len;
    in_ch.code_bits   <= bits;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_and_pack(action_t act, logic [7:0] sym, logic [5:0] len,
                               logic [31:0] bits);
    send_item(act, sym, len, bits);
    pack_item(act, sym, len, bits);
    foreach (step_beats[k])
      owed_beats.push_back(step_beats[k]);
  endtask

  task automatic check_beat(beat_t got);
    beat_t want;
    if (owed_beats.size() == 0) begin
      report("unexpected beat, kind", 32'd0, 32'(got.kind));
      return;
    end
    want = owed_beats.pop_front();
    if (got.kind != want.kind)             report("kind", 32'(want.kind), 32'(got.kind));
    if (got.out_byte != want.out_byte)     report("out_byte", 32'(want.out_byte),
                                                  32'(got.out_byte));
    if (got.byte_total != want.byte_total) report("byte_total", want.byte_total,
                                                  got.byte_total);
    if (got.last != want.last)             report("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int    gap;
    beat_t got;
    out_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0)
        quiet_rx = !quiet_rx;
      gap = quiet_rx ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got = '{kind_t'(out_ch.kind), out_ch.out_byte, out_ch.byte_total, out_ch.last};
      check_beat(got);
    end
  end

  initial begin
    row_t        row;
    int          taken;
    int          pick;
    action_t     act;
    logic [7:0]  sym;
    logic [5:0]  len;
    bit          held;
    bit          drained;

    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_NONE;
    in_ch.symbol      <= '0;
    in_ch.code_length <= '0;
    in_ch.code_bits   <= '0;
    acc_bits   = '0;
    acc_count  = '0;
    bytes_sent = '0;
    foreach (loaded[k])
      loaded[k] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      send_item(row.act, row.sym, row.len, row.bits);
      pack_item(row.act, row.sym, row.len, row.bits);
      if (row.typed) begin
        if (row.n_typed >= 2'd1) owed_beats.push_back(row.b0);
        if (row.n_typed >= 2'd2) owed_beats.push_back(row.b1);
      end else begin
        foreach (step_beats[k])
          owed_beats.push_back(step_beats[k]);
      end
    end

    taken   = 0;
    held    = 1'b0;
    drained = 1'b0;
    while (taken < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      sym  = 8'($urandom_range(0, 255));
      len  = 6'($urandom_range(0, 63));
      if (pick < 15) begin
        act = ACT_LOAD;
        case ($urandom_range(0, 9))
          0:       len = 6'd0;
          1:       len = 6'($urandom_range(33, 63));
          2:       len = 6'd32;
          default: len = 6'($urandom_range(1, 20));
        endcase
      end else if (pick < 85) begin
        act = ACT_ENCODE;
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      end else if (pick < 95) begin
        act = ACT_FLUSH;
      end else begin
        act = ACT_NONE;
      end
      send_and_pack(act, sym, len, $urandom());
      if (act != ACT_NONE)
        taken++;
      // Stall the receiver while items keep coming.
      if (taken == 100 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      // Pause input until every owed beat is out.
      if (taken == 200 && !drained) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
